[rtl/thp_pkg.sv]
// shared types, constants and helpers for the sensor compensation pipeline
// no dependencies; every rtl file refers to this package by scoped names
package thp_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM     = 3'd4;
	localparam int unsigned CFG_DATA_W = 64;

	// pipeline depths
	localparam int unsigned TEMP_STAGES  = 3;
	localparam int unsigned FRONT_STAGES = 8;
	localparam int unsigned DIV_W        = 32;
	localparam int unsigned DIV_STAGES   = DIV_W;
	localparam int unsigned BACK_STAGES  = 3;

	// formula constants
	localparam logic [31:0] PRESS_MAX = 32'd262143;
	localparam logic [31:0] HUM_CLAMP = 32'd419430400;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} raw_t;

	typedef struct packed {
		logic signed [15:0] temperature_x100;
		logic [17:0]        pressure_pa;
		logic               pressure_invalid;
		logic [16:0]        humidity_q22_10;
		logic [13:0]        humidity_x100;
	} res_t;

	// coefficients, zero or sign extended to 32 bits
	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
	} coef_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [15:0] tout;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} temp_t;

	// values that ride alongside the divider
	typedef struct packed {
		logic        post;
		logic        inv;
		logic [15:0] tout;
		logic [16:0] hq;
		logic [13:0] hx;
	} div_side_t;

	typedef struct packed {
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
		div_side_t        side;
	} div_in_t;

	typedef struct packed {
		logic [DIV_W-1:0] quot;
		div_side_t        side;
	} div_out_t;

	// 32-bit arithmetic right shift
	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		asr32 = $signed(x) >>> n;
	endfunction

endpackage

[rtl/thp_sensor_compensation.sv]
// top level: calibration registers and the compensation pipeline
// depends on thp_pkg, thp_temp, thp_front, thp_div, thp_back
//
// usage: raw temperature, pressure and humidity readings enter on the in
// channel (in_valid / in_stall / in_data) and compensated readings leave on
// the out channel (out_valid / out_stall / out_data), one result per reading,
// in order. a transaction completes at a clock edge with valid high and
// stall low.
// calibration coefficients are written through cfg_write / cfg_index /
// cfg_data while the pipeline is empty; indexes above the last register
// are ignored.
// throughput: one reading per cycle while the out channel does not stall;
// readings pass through 3 temperature stages, 8 pressure/humidity stages, 32
// divider stages of one quotient bit each, and 3 correction and output stages.
// reset clears all calibration registers to zero and empties the pipeline.
// when the receiver stalls, the output register holds and bubbles inside the
// pipeline still close up, so input keeps being taken until every stage is
// full; then in_stall rises.
module thp_sensor_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [thp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [thp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  thp_pkg::raw_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output thp_pkg::res_t                    out_data
);
	logic [47:0] temp_calib_q;
	logic [63:0] press_a_q, press_b_q, hum_calib_q;
	logic [15:0] press_c_q;

	// calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
			hum_calib_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				thp_pkg::CFG_TEMP:    temp_calib_q <= cfg_data[47:0];
				thp_pkg::CFG_PRESS_A: press_a_q    <= cfg_data;
				thp_pkg::CFG_PRESS_B: press_b_q    <= cfg_data;
				thp_pkg::CFG_PRESS_C: press_c_q    <= cfg_data[15:0];
				thp_pkg::CFG_HUM:     hum_calib_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient unpacking with sign extension
	thp_pkg::coef_t coef;
	always_comb begin
		coef.t1 = {16'd0, temp_calib_q[15:0]};
		coef.t2 = {{16{temp_calib_q[31]}}, temp_calib_q[31:16]};
		coef.t3 = {{16{temp_calib_q[47]}}, temp_calib_q[47:32]};
		coef.p1 = {16'd0, press_a_q[15:0]};
		coef.p2 = {{16{press_a_q[31]}}, press_a_q[31:16]};
		coef.p3 = {{16{press_a_q[47]}}, press_a_q[47:32]};
		coef.p4 = {{16{press_a_q[63]}}, press_a_q[63:48]};
		coef.p5 = {{16{press_b_q[15]}}, press_b_q[15:0]};
		coef.p6 = {{16{press_b_q[31]}}, press_b_q[31:16]};
		coef.p7 = {{16{press_b_q[47]}}, press_b_q[47:32]};
		coef.p8 = {{16{press_b_q[63]}}, press_b_q[63:48]};
		coef.p9 = {{16{press_c_q[15]}}, press_c_q};
		coef.h1 = {24'd0, hum_calib_q[7:0]};
		coef.h2 = {{16{hum_calib_q[23]}}, hum_calib_q[23:8]};
		coef.h3 = {24'd0, hum_calib_q[31:24]};
		coef.h4 = {{20{hum_calib_q[43]}}, hum_calib_q[43:32]};
		coef.h5 = {{20{hum_calib_q[55]}}, hum_calib_q[55:44]};
		coef.h6 = {{24{hum_calib_q[63]}}, hum_calib_q[63:56]};
	end

	logic              t_valid, t_stall, f_valid, f_stall, d_valid, d_stall;
	thp_pkg::temp_t    t_data;
	thp_pkg::div_in_t  f_data;
	thp_pkg::div_out_t d_data;

	thp_temp u_temp (
		.clk(clk), .arst_n(arst_n), .coef(coef),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(t_valid), .out_stall(t_stall), .out_data(t_data)
	);

	thp_front u_front (
		.clk(clk), .arst_n(arst_n), .coef(coef),
		.in_valid(t_valid), .in_stall(t_stall), .in_data(t_data),
		.out_valid(f_valid), .out_stall(f_stall), .out_data(f_data)
	);

	thp_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
		.out_valid(d_valid), .out_stall(d_stall), .out_data(d_data)
	);

	thp_back u_back (
		.clk(clk), .arst_n(arst_n), .coef(coef),
		.in_valid(d_valid), .in_stall(d_stall), .in_data(d_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// invalid pressure always reads as zero
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pressure_invalid |-> out_data.pressure_pa == '0)
		else $error("invalid pressure not forced to zero");

	// humidity stays within its clamp
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.humidity_q22_10 <= 17'd102400
			&& out_data.humidity_x100 <= 14'd10000)
		else $error("humidity out of range");

	// a divider transaction passes on into the back stages without loss
	a_div_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		d_valid && !d_stall |=> u_back.vld_q[0])
		else $error("divider handoff lost");

	// the input may only stall while the output side holds a result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

endmodule

[rtl/thp_temp.sv]
// temperature stages: fine temperature and saturated hundredths of a degree
// depends on thp_pkg
module thp_temp (
	input  logic           clk,
	input  logic           arst_n,
	input  thp_pkg::coef_t coef,
	input  logic           in_valid,
	output logic           in_stall,
	input  thp_pkg::raw_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output thp_pkg::temp_t out_data
);
	localparam int unsigned N = thp_pkg::TEMP_STAGES;

	logic [N-1:0] vld_q;
	logic [N-1:0] adv;

	// stage advance chain
	assign adv[N-1] = !vld_q[N-1] || !out_stall;
	for (genvar k = 0; k < N-1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_stall  = !adv[0];
	assign out_valid = vld_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	logic [31:0] a_s1, dd_s1, fine_s2;
	logic [19:0] rawp_s1, rawp_s2;
	logic [15:0] rawh_s1, rawh_s2;
	logic [31:0] x1, d1, b2, t3;
	logic [15:0] tsat;

	// stage 1: linear and square terms
	always_comb begin
		x1 = {15'd0, in_data.raw_temperature[19:3]} - {coef.t1[30:0], 1'b0};
		d1 = {16'd0, in_data.raw_temperature[19:4]} - coef.t1;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			a_s1    <= thp_pkg::asr32(x1 * coef.t2, 11);
			dd_s1   <= d1 * d1;
			rawp_s1 <= in_data.raw_pressure;
			rawh_s1 <= in_data.raw_humidity;
		end
	end

	// stage 2: fine temperature
	assign b2 = thp_pkg::asr32(thp_pkg::asr32(dd_s1, 12) * coef.t3, 14);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			fine_s2 <= a_s1 + b2;
			rawp_s2 <= rawp_s1;
			rawh_s2 <= rawh_s1;
		end
	end

	// stage 3: scale and saturate
	always_comb begin
		t3 = thp_pkg::asr32(fine_s2 * 32'd5 + 32'd128, 8);
		if ($signed(t3) < -32'sd32768) tsat = 16'h8000;
		else if ($signed(t3) > 32'sd32767) tsat = 16'h7fff;
		else tsat = t3[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			out_data.fine         <= fine_s2;
			out_data.tout         <= tsat;
			out_data.raw_pressure <= rawp_s2;
			out_data.raw_humidity <= rawh_s2;
		end
	end

endmodule

[rtl/thp_front.sv]
// pressure terms up to the divider operands, and the full humidity formula
// depends on thp_pkg
module thp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  thp_pkg::coef_t   coef,
	input  logic             in_valid,
	output logic             in_stall,
	input  thp_pkg::temp_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output thp_pkg::div_in_t out_data
);
	localparam int unsigned N = thp_pkg::FRONT_STAGES;

	logic [N-1:0] vld_q;
	logic [N-1:0] adv;

	// stage advance chain
	assign adv[N-1] = !vld_q[N-1] || !out_stall;
	for (genvar k = 0; k < N-1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_stall  = !adv[0];
	assign out_valid = vld_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	logic [15:0] tout_s1, tout_s2, tout_s3, tout_s4, tout_s5, tout_s6, tout_s7;
	logic [19:0] rawp_s1, rawp_s2, rawp_s3;
	logic [31:0] pd2_s1, pm5_s1, pm2_s1, hm5_s1, hm6_s1, hm3_s1, hx0_s1;
	logic [31:0] pb1_s2, pm3_s2, pm5_s2, pm2_s2, ha_s2, hb_s2, hc_s2;
	logic [31:0] pb_s3, px_s3, he_s3, ha_s3;
	logic [31:0] pdiv_s4, pnum_s4, hf_s4, ha_s4;
	logic [31:0] pm_s5, pdiv_s5, hv_s5;
	logic [31:0] dvd_s6, pdiv_s6, hd2_s6, hv_s6;
	logic        post_s6, inv_s6, post_s7, inv_s7;
	logic [31:0] dvd_s7, pdiv_s7, hh_s7, hv_s7;
	logic [31:0] pa, pd, hv, hd, hv3, hcl;
	logic [16:0] hq;
	logic [23:0] hprod;

	// stage 1: offsets from fine temperature, first products
	always_comb begin
		pa = thp_pkg::asr32(in_data.fine, 1) - 32'd64000;
		pd = thp_pkg::asr32(pa, 2);
		hv = in_data.fine - 32'd76800;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			pd2_s1  <= pd * pd;
			pm5_s1  <= pa * coef.p5;
			pm2_s1  <= coef.p2 * pa;
			hm5_s1  <= coef.h5 * hv;
			hm6_s1  <= hv * coef.h6;
			hm3_s1  <= hv * coef.h3;
			hx0_s1  <= {2'd0, in_data.raw_humidity, 14'd0} - {coef.h4[11:0], 20'd0};
			rawp_s1 <= in_data.raw_pressure;
			tout_s1 <= in_data.tout;
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pb1_s2  <= thp_pkg::asr32(pd2_s1, 11) * coef.p6;
			pm3_s2  <= coef.p3 * thp_pkg::asr32(pd2_s1, 13);
			pm5_s2  <= pm5_s1;
			pm2_s2  <= pm2_s1;
			ha_s2   <= thp_pkg::asr32(hx0_s1 - hm5_s1 + 32'd16384, 15);
			hb_s2   <= thp_pkg::asr32(hm6_s1, 10);
			hc_s2   <= thp_pkg::asr32(hm3_s1, 11) + 32'd32768;
			rawp_s2 <= rawp_s1;
			tout_s2 <= tout_s1;
		end
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pb_s3   <= thp_pkg::asr32(pb1_s2 + {pm5_s2[30:0], 1'b0}, 2)
				+ {coef.p4[15:0], 16'd0};
			px_s3   <= 32'd32768 + thp_pkg::asr32(thp_pkg::asr32(pm3_s2, 3)
				+ thp_pkg::asr32(pm2_s2, 1), 18);
			he_s3   <= thp_pkg::asr32(hb_s2 * hc_s2, 10) + 32'd2097152;
			ha_s3   <= ha_s2;
			rawp_s3 <= rawp_s2;
			tout_s3 <= tout_s2;
		end
	end

	// stage 4: divisor and numerator base
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			pdiv_s4 <= thp_pkg::asr32(px_s3 * coef.p1, 15);
			pnum_s4 <= 32'd1048576 - {12'd0, rawp_s3} - thp_pkg::asr32(pb_s3, 12);
			hf_s4   <= thp_pkg::asr32(he_s3 * coef.h2 + 32'd8192, 14);
			ha_s4   <= ha_s3;
			tout_s4 <= tout_s3;
		end
	end

	// stage 5
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			pm_s5   <= pnum_s4 * 32'd3125;
			pdiv_s5 <= pdiv_s4;
			hv_s5   <= ha_s4 * hf_s4;
			tout_s5 <= tout_s4;
		end
	end

	// stage 6: pick the division branch
	assign hd = thp_pkg::asr32(hv_s5, 15);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			post_s6 <= pm_s5[31];
			dvd_s6  <= pm_s5[31] ? pm_s5 : {pm_s5[30:0], 1'b0};
			pdiv_s6 <= pdiv_s5;
			inv_s6  <= (pdiv_s5 == 32'd0);
			hd2_s6  <= hd * hd;
			hv_s6   <= hv_s5;
			tout_s6 <= tout_s5;
		end
	end

	// stage 7
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			hh_s7   <= thp_pkg::asr32(hd2_s6, 7) * coef.h1;
			hv_s7   <= hv_s6;
			post_s7 <= post_s6;
			inv_s7  <= inv_s6;
			dvd_s7  <= dvd_s6;
			pdiv_s7 <= pdiv_s6;
			tout_s7 <= tout_s6;
		end
	end

	// stage 8: humidity clamp and percent conversion
	always_comb begin
		hv3 = hv_s7 - thp_pkg::asr32(hh_s7, 4);
		if (hv3[31]) hcl = 32'd0;
		else if (hv3 > thp_pkg::HUM_CLAMP) hcl = thp_pkg::HUM_CLAMP;
		else hcl = hv3;
		hq    = hcl[28:12];
		hprod = {7'd0, hq} * 24'd100;
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			out_data.dividend  <= dvd_s7;
			out_data.divisor   <= pdiv_s7;
			out_data.side.post <= post_s7;
			out_data.side.inv  <= inv_s7;
			out_data.side.tout <= tout_s7;
			out_data.side.hq   <= hq;
			out_data.side.hx   <= hprod[23:10];
		end
	end

endmodule

[rtl/thp_div.sv]
// pipelined restoring unsigned divider, one quotient bit per stage
// depends on thp_pkg
module thp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  thp_pkg::div_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output thp_pkg::div_out_t out_data
);
	localparam int unsigned N = thp_pkg::DIV_STAGES;
	localparam int unsigned W = thp_pkg::DIV_W;

	logic [N-1:0] vld_q;
	logic [N-1:0] adv;

	// stage advance chain
	assign adv[N-1] = !vld_q[N-1] || !out_stall;
	for (genvar k = 0; k < N-1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_stall  = !adv[0];
	assign out_valid = vld_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	logic [W-1:0]       rem_s [N];
	logic [W-1:0]       dq_s  [N];
	logic [W-1:0]       dvs_s [N];
	thp_pkg::div_side_t side_s[N];

	// each stage shifts in one dividend bit and trial-subtracts the divisor
	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [W-1:0]       rem_in, dq_in, dvs_in;
		thp_pkg::div_side_t side_in;
		logic [W:0]         trial, diff;
		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign dq_in   = in_data.dividend;
			assign dvs_in  = in_data.divisor;
			assign side_in = in_data.side;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign dq_in   = dq_s[k-1];
			assign dvs_in  = dvs_s[k-1];
			assign side_in = side_s[k-1];
		end
		assign trial = {rem_in, dq_in[W-1]};
		assign diff  = trial - {1'b0, dvs_in};
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k]  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
				dq_s[k]   <= {dq_in[W-2:0], !diff[W]};
				dvs_s[k]  <= dvs_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_data.quot = dq_s[N-1];
	assign out_data.side = side_s[N-1];

endmodule

[rtl/thp_back.sv]
// pressure correction after the division, saturation and result register
// depends on thp_pkg
module thp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  thp_pkg::coef_t    coef,
	input  logic              in_valid,
	output logic              in_stall,
	input  thp_pkg::div_out_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output thp_pkg::res_t     out_data
);
	localparam int unsigned N = thp_pkg::BACK_STAGES;

	logic [N-1:0] vld_q;
	logic [N-1:0] adv;

	// stage advance chain
	assign adv[N-1] = !vld_q[N-1] || !out_stall;
	for (genvar k = 0; k < N-1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_stall  = !adv[0];
	assign out_valid = vld_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	logic [31:0] p0, p3x, pf;
	logic [31:0] p_s1, c_s1, m8_s1, p_s2, a_s2, b_s2;
	thp_pkg::div_side_t side_s1, side_s2;

	// stage 1: undo the branch scaling, square term
	always_comb begin
		p0  = in_data.side.post ? {in_data.quot[30:0], 1'b0} : in_data.quot;
		p3x = {3'd0, p0[31:3]};
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			p_s1    <= p0;
			c_s1    <= p3x * p3x;
			m8_s1   <= {2'd0, p0[31:2]} * coef.p8;
			side_s1 <= in_data.side;
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			a_s2    <= thp_pkg::asr32(coef.p9 * {13'd0, c_s1[31:13]}, 12);
			b_s2    <= thp_pkg::asr32(m8_s1, 13);
			p_s2    <= p_s1;
			side_s2 <= side_s1;
		end
	end

	// stage 3: final pressure, invalid override
	assign pf = p_s2 + thp_pkg::asr32(a_s2 + b_s2 + coef.p7, 4);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			out_data.temperature_x100 <= side_s2.tout;
			out_data.pressure_invalid <= side_s2.inv;
			if (side_s2.inv) out_data.pressure_pa <= '0;
			else if (pf > thp_pkg::PRESS_MAX) out_data.pressure_pa <= thp_pkg::PRESS_MAX[17:0];
			else out_data.pressure_pa <= pf[17:0];
			out_data.humidity_q22_10 <= side_s2.hq;
			out_data.humidity_x100   <= side_s2.hx;
		end
	end

endmodule
